// ===== rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotation core.
// No dependencies; the core and its submodules use it through scoped names.
package qvr_pkg;

  typedef logic signed [63:0] s64_t;

  // One input item: quaternion (x, y, z, w) and vector (x, y, z), raw Q16.16
  typedef struct packed {
    logic [3:0][31:0] q;
    logic [2:0][31:0] v;
  } item_t;

  // Context carried through the reciprocal pipeline
  typedef struct packed {
    item_t            item;
    logic [3:0][31:0] mag;
    logic             zero;
    logic [31:0]      m;
    logic [4:0]       k;
    logic [32:0]      r;
    logic [32:0]      e;
  } nt_t;

  // Context carried through the square root pipeline
  typedef struct packed {
    item_t            item;
    logic [3:0][31:0] mag;
    logic [63:0]      x;
    logic [63:0]      r;
  } sq_t;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [32:0] RECIP_SEED = 33'h0_c000_0000;
  localparam logic [63:0] NEWTON_TWO = 64'h8000_0000_0000_0000;

endpackage

// ===== rtl/qvr_if.sv =====
// Valid/ready channel interfaces of the quaternion vector rotation core.
// No dependencies.
interface qvr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] quat_x;
  logic [31:0] quat_y;
  logic [31:0] quat_z;
  logic [31:0] quat_w;
  logic [31:0] vec_x;
  logic [31:0] vec_y;
  logic [31:0] vec_z;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface qvr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rot_x;
  logic [31:0] rot_y;
  logic [31:0] rot_z;
  logic        zero_norm;
  logic        saturated;
  modport source (output valid, rot_x, rot_y, rot_z, zero_norm, saturated, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, zero_norm, saturated, output ready);
endinterface

// ===== rtl/qvr_norm.sv =====
// Quaternion norm: magnitudes, squares, saturating sum, pipelined integer sqrt.
// Depends on qvr_pkg.
module qvr_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  qvr_pkg::item_t      in_item,
  output logic                out_valid,
  output qvr_pkg::item_t      out_item,
  output logic [3:0][31:0]    out_mag,
  output logic [31:0]         out_n
);

  logic                v1_r, v2_r;
  qvr_pkg::item_t      item1_r, item2_r;
  logic [3:0][31:0]    mag1_r, mag2_r, mag_nxt;
  logic [3:0][63:0]    sq_r;
  logic [65:0]         sum_wide;
  logic [63:0]         sum_sat;

  qvr_pkg::sq_t        st_r   [33];
  qvr_pkg::sq_t        st_nxt [33];
  logic                sv_r   [33];

  // absolute values; -2^31 maps to 2^31 unsigned
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_nxt[i] = in_item.q[i][31] ? (~in_item.q[i] + 32'd1) : in_item.q[i];
    end
  end

  // sum of squares saturates at 2^64-1
  always_comb begin
    sum_wide = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]) + 66'(sq_r[3]);
    sum_sat  = (sum_wide[65:64] != 2'b00) ? '1 : sum_wide[63:0];
  end

  // one restoring sqrt step per stage
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    st_nxt[0] = '0;
    for (int j = 0; j < 32; j++) begin
      bitv  = 64'd1 << (62 - 2 * j);
      trial = st_r[j].r + bitv;
      st_nxt[j+1] = st_r[j];
      if (st_r[j].x >= trial) begin
        st_nxt[j+1].x = st_r[j].x - trial;
        st_nxt[j+1].r = (st_r[j].r >> 1) + bitv;
      end else begin
        st_nxt[j+1].r = st_r[j].r >> 1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int j = 0; j < 33; j++) sv_r[j] <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      sv_r[0] <= v2_r;
      for (int j = 0; j < 32; j++) sv_r[j+1] <= sv_r[j];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      item1_r <= in_item;
      mag1_r  <= mag_nxt;
      item2_r <= item1_r;
      mag2_r  <= mag1_r;
      for (int i = 0; i < 4; i++) sq_r[i] <= 64'(mag1_r[i]) * 64'(mag1_r[i]);
      st_r[0].item <= item2_r;
      st_r[0].mag  <= mag2_r;
      st_r[0].x    <= sum_sat;
      st_r[0].r    <= '0;
      for (int j = 1; j < 33; j++) st_r[j] <= st_nxt[j];
    end
  end

  assign out_valid = sv_r[32];
  assign out_item  = st_r[32].item;
  assign out_mag   = st_r[32].mag;
  assign out_n     = st_r[32].r[31:0];

endmodule

// ===== rtl/qvr_recip.sv =====
// Reciprocal of the norm by Newton steps and normalization of the quaternion.
// Depends on qvr_pkg.
module qvr_recip #(
  parameter int NEWTON_STEPS = 4,
  parameter int FRAC_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [15:0]         norm_eps,
  input  logic                in_valid,
  input  qvr_pkg::item_t      in_item,
  input  logic [3:0][31:0]    in_mag,
  input  logic [31:0]         in_n,
  output logic                out_valid,
  output qvr_pkg::item_t      out_item,
  output logic [3:0][63:0]    out_q,
  output logic                out_zero
);

  localparam int NS = 2 * NEWTON_STEPS;
  localparam qvr_pkg::s64_t QLIM = (FRAC_BITS >= 15) ? (64'sd1 <<< (FRAC_BITS + 1))
                                                     : (64'sd1 <<< 16);
  localparam logic [6:0] SHIFT_BASE = 7'(62 - FRAC_BITS);

  qvr_pkg::nt_t     nt_r   [NS+1];
  qvr_pkg::nt_t     nt0_nxt;
  qvr_pkg::nt_t     nt_nxt [1:NS];
  logic             nv_r   [NS+1];

  logic             pv_r;
  qvr_pkg::nt_t     p_r;
  logic [3:0][63:0] prod_r;

  logic [3:0][63:0] q_nxt;

  // leading-zero shift of the norm and seed of the reciprocal
  always_comb begin
    logic [31:0] m;
    logic [4:0]  k;
    m = in_n;
    k = '0;
    if (m[31:16] == 16'd0) begin m = m << 16; k = k + 5'd16; end
    if (m[31:24] == 8'd0)  begin m = m << 8;  k = k + 5'd8;  end
    if (m[31:28] == 4'd0)  begin m = m << 4;  k = k + 5'd4;  end
    if (m[31:30] == 2'd0)  begin m = m << 2;  k = k + 5'd2;  end
    if (m[31] == 1'b0)     begin m = m << 1;  k = k + 5'd1;  end
    nt0_nxt.item = in_item;
    nt0_nxt.mag  = in_mag;
    nt0_nxt.zero = (in_n <= 32'(norm_eps));
    nt0_nxt.m    = m;
    nt0_nxt.k    = k;
    nt0_nxt.r    = qvr_pkg::RECIP_SEED - 33'(m >> 1);
    nt0_nxt.e    = '0;
  end

  // Newton steps, two stages each: error term, then refined reciprocal
  always_comb begin
    logic [63:0] mr;
    logic [65:0] re;
    for (int s = 0; s < NS; s++) begin
      nt_nxt[s+1] = nt_r[s];
      if ((s % 2) == 0) begin
        mr = 64'(65'(nt_r[s].m) * 65'(nt_r[s].r));
        nt_nxt[s+1].e = 33'((qvr_pkg::NEWTON_TWO - mr) >> 31);
        re = '0;
      end else begin
        mr = '0;
        re = 66'(nt_r[s].r) * 66'(nt_r[s].e);
        nt_nxt[s+1].r = re[63:31];
      end
    end
  end

  // scale back, round half away from zero, apply sign (raw component on a zero norm), clamp
  always_comb begin
    logic [6:0]    sh;
    logic [63:0]   p;
    qvr_pkg::s64_t sp;
    sh = SHIFT_BASE - 7'(p_r.k);
    for (int i = 0; i < 4; i++) begin
      p  = (prod_r[i] + (64'd1 << (sh - 7'd1))) >> sh;
      sp = p_r.item.q[i][31] ? -$signed(p) : $signed(p);
      if (p_r.zero) sp = 64'($signed(p_r.item.q[i]));
      if (sp > QLIM)       sp = QLIM;
      else if (sp < -QLIM) sp = -QLIM;
      q_nxt[i] = sp;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) nv_r[s] <= 1'b0;
      pv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      nv_r[0] <= in_valid;
      for (int s = 0; s < NS; s++) nv_r[s+1] <= nv_r[s];
      pv_r      <= nv_r[NS];
      out_valid <= pv_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      nt_r[0] <= nt0_nxt;
      for (int s = 1; s <= NS; s++) nt_r[s] <= nt_nxt[s];
      p_r <= nt_r[NS];
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= 64'(65'(nt_r[NS].mag[i]) * 65'(nt_r[NS].r));
      end
      out_item <= p_r.item;
      out_zero <= p_r.zero;
      out_q    <= q_nxt;
    end
  end

endmodule

// ===== rtl/qvr_rotate.sv =====
// Rotation v' = v + w t + q x t with t = 2 (q x v), then saturation.
// Depends on qvr_pkg.
module qvr_rotate #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  qvr_pkg::item_t      in_item,
  input  logic [3:0][63:0]    in_q,
  input  logic                in_zero,
  output logic                out_valid,
  output logic [2:0][31:0]    out_rot,
  output logic                out_zero,
  output logic                out_sat
);

  // clamped quaternion components fit in QW signed bits, t in TW
  localparam int QW = (FRAC_BITS >= 15) ? FRAC_BITS + 3 : 18;
  localparam int TW = QW + 33 - FRAC_BITS;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               z1_r, z2_r, z3_r, z4_r;
  logic [3:0][63:0]   q1_r, q2_r;
  logic [2:0][31:0]   vv1_r, vv2_r, vv3_r;
  logic [5:0][63:0]   pa_r, pb_r, pa_nxt, pb_nxt;
  logic [2:0][63:0]   t_r, t_nxt, pw_r, pw_nxt, sum_r, sum_nxt;
  logic [2:0][31:0]   rot_nxt;
  logic [2:0]         sat_nxt;

  // first cross product q x v
  always_comb begin
    logic signed [QW-1:0] a [3];
    logic signed [31:0]   b [3];
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(in_q[i][QW-1:0]);
      b[i] = $signed(in_item.v[i]);
    end
    pa_nxt[0] = 64'(a[1] * b[2]);
    pa_nxt[1] = 64'(a[2] * b[1]);
    pa_nxt[2] = 64'(a[2] * b[0]);
    pa_nxt[3] = 64'(a[0] * b[2]);
    pa_nxt[4] = 64'(a[0] * b[1]);
    pa_nxt[5] = 64'(a[1] * b[0]);
  end

  // t = 2 * floor((q x v) / 2^F)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_nxt[i] = (($signed(pa_r[2*i]) - $signed(pa_r[2*i+1])) >>> FRAC_BITS) <<< 1;
    end
  end

  // second cross product q x t and w t; q2_r is aligned with t_r
  always_comb begin
    logic signed [QW-1:0] a [4];
    logic signed [TW-1:0] b [3];
    for (int i = 0; i < 4; i++) a[i] = $signed(q2_r[i][QW-1:0]);
    for (int i = 0; i < 3; i++) begin
      b[i]      = $signed(t_r[i][TW-1:0]);
      pw_nxt[i] = 64'(a[3] * b[i]);
    end
    pb_nxt[0] = 64'(a[1] * b[2]);
    pb_nxt[1] = 64'(a[2] * b[1]);
    pb_nxt[2] = 64'(a[2] * b[0]);
    pb_nxt[3] = 64'(a[0] * b[2]);
    pb_nxt[4] = 64'(a[0] * b[1]);
    pb_nxt[5] = 64'(a[1] * b[0]);
  end

  // v + floor(w t / 2^F) + floor((q x t) / 2^F)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = 64'($signed(vv3_r[i])) + ($signed(pw_r[i]) >>> FRAC_BITS)
                 + (($signed(pb_r[2*i]) - $signed(pb_r[2*i+1])) >>> FRAC_BITS);
    end
  end

  // saturate to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_nxt[i] = 1'b1;
      if ($signed(sum_r[i]) > 64'($signed(qvr_pkg::S32_MAX))) begin
        rot_nxt[i] = qvr_pkg::S32_MAX;
      end else if ($signed(sum_r[i]) < 64'($signed(qvr_pkg::S32_MIN))) begin
        rot_nxt[i] = qvr_pkg::S32_MIN;
      end else begin
        rot_nxt[i] = sum_r[i][31:0];
        sat_nxt[i] = 1'b0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      out_valid <= v4_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r     <= pa_nxt;
      q1_r     <= in_q;
      vv1_r    <= in_item.v;
      z1_r     <= in_zero;
      t_r      <= t_nxt;
      q2_r     <= q1_r;
      vv2_r    <= vv1_r;
      z2_r     <= z1_r;
      pb_r     <= pb_nxt;
      pw_r     <= pw_nxt;
      vv3_r    <= vv2_r;
      z3_r     <= z2_r;
      sum_r    <= sum_nxt;
      z4_r     <= z3_r;
      out_rot  <= rot_nxt;
      out_zero <= z4_r;
      out_sat  <= |sat_nxt;
    end
  end

endmodule

// ===== rtl/quaternion_vector_rotate_core.sv =====
// Quaternion vector rotation core: norm, Newton reciprocal, rotation, saturation.
// Pipeline depth is set by the 32-stage square root and two stages per Newton step.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline and sets norm_epsilon to 1.
// Depends on qvr_pkg, qvr_if, qvr_norm, qvr_recip, qvr_rotate.
module quaternion_vector_rotate_core #(
  parameter int NEWTON_STEPS = 4,
  parameter int FRAC_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  qvr_in_if.sink        in_ch,
  qvr_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  logic                adv;
  logic [15:0]         eps_r;
  qvr_pkg::item_t      in_item;

  logic                n_valid;
  qvr_pkg::item_t      n_item;
  logic [3:0][31:0]    n_mag;
  logic [31:0]         n_norm;

  logic                r_valid;
  qvr_pkg::item_t      r_item;
  logic [3:0][63:0]    r_q;
  logic                r_zero;

  logic [2:0][31:0]    rot;

  // pipeline moves whenever the output register is free or being taken
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= 16'd1;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  assign in_item.q = {in_ch.quat_w, in_ch.quat_z, in_ch.quat_y, in_ch.quat_x};
  assign in_item.v = {in_ch.vec_z, in_ch.vec_y, in_ch.vec_x};

  qvr_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .out_valid(n_valid),
    .out_item (n_item),
    .out_mag  (n_mag),
    .out_n    (n_norm)
  );

  qvr_recip #(
    .NEWTON_STEPS(NEWTON_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .norm_eps (eps_r),
    .in_valid (n_valid),
    .in_item  (n_item),
    .in_mag   (n_mag),
    .in_n     (n_norm),
    .out_valid(r_valid),
    .out_item (r_item),
    .out_q    (r_q),
    .out_zero (r_zero)
  );

  qvr_rotate #(
    .FRAC_BITS(FRAC_BITS)
  ) u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (r_valid),
    .in_item  (r_item),
    .in_q     (r_q),
    .in_zero  (r_zero),
    .out_valid(out_ch.valid),
    .out_rot  (rot),
    .out_zero (out_ch.zero_norm),
    .out_sat  (out_ch.saturated)
  );

  assign out_ch.rot_x = rot[0];
  assign out_ch.rot_y = rot[1];
  assign out_ch.rot_z = rot[2];

  // a flagged result holds a clamp value in some component
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (out_ch.rot_x == qvr_pkg::S32_MAX) || (out_ch.rot_x == qvr_pkg::S32_MIN) ||
      (out_ch.rot_y == qvr_pkg::S32_MAX) || (out_ch.rot_y == qvr_pkg::S32_MIN) ||
      (out_ch.rot_z == qvr_pkg::S32_MAX) || (out_ch.rot_z == qvr_pkg::S32_MIN))
    else $error("saturated flag without clamped component");

  // a waiting result stalls intake
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while result stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

// ===== verif/tb_qvr_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces live with the RTL (rtl/qvr_if.sv).
// This file holds a small package of item types used by the bench; no dependencies.
package tb_qvr_pkg;

  // One input item as driven onto the input channel
  typedef struct packed {
    logic [31:0] qx, qy, qz, qw;
    logic [31:0] vx, vy, vz;
  } rot_req_t;

  // One result item as seen on the output channel
  typedef struct packed {
    logic [31:0] rx, ry, rz;
    logic        zero_norm;
    logic        saturated;
  } rot_res_t;

endpackage

// ===== verif/tb_quaternion_vector_rotate_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quaternion_vector_rotate_core: directed and random items
// through the valid/ready channels, checked against a fixed-point rotation predictor.
// Depends on qvr_if, tb_qvr_pkg and the core RTL.
module tb_quaternion_vector_rotate_core;

  localparam int FRAC = 16;
  localparam int NSTEPS = 4;
  localparam int LATENCY = 43 + 2 * NSTEPS;
  localparam logic signed [63:0] QBOUND = 64'sd1 <<< (FRAC + 1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  qvr_in_if  in_ch();
  qvr_out_if out_ch();

  quaternion_vector_rotate_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tb_qvr_pkg::rot_req_t pending_items[$];
  tb_qvr_pkg::rot_res_t expected_rots[$];
  logic [15:0] epsilon_now;
  int send_idle_pct, recv_idle_pct;
  int mismatches = 0;
  int accepted = 0;

  // Arithmetic shift right, floor rounding
  function automatic logic signed [63:0] fshr(input logic signed [63:0] x);
    fshr = x >>> FRAC;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    int_sqrt = r;
  endfunction

  // Predicted rotation result of one item under the current epsilon
  function automatic tb_qvr_pkg::rot_res_t rotate_item(input tb_qvr_pkg::rot_req_t it,
                                                       input logic [15:0] eps);
    logic signed [63:0] q[4], v[3], t[3], c[3], s;
    logic [63:0] mag[4], sq, sum, n, m, r, e, p;
    int k, sh;
    bit sat;
    tb_qvr_pkg::rot_res_t res;
    q[0] = $signed(it.qx); q[1] = $signed(it.qy);
    q[2] = $signed(it.qz); q[3] = $signed(it.qw);
    v[0] = $signed(it.vx); v[1] = $signed(it.vy); v[2] = $signed(it.vz);
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = q[i] < 0 ? -q[i] : q[i];
      sq = mag[i] * mag[i];
      sum = (sum + sq < sum) ? 64'hffff_ffff_ffff_ffff : sum + sq;
    end
    n = int_sqrt(sum);
    res.zero_norm = (n <= {48'd0, eps});
    if (!res.zero_norm) begin
      k = 0;
      m = n;
      while (m[31] == 1'b0) begin
        m = m << 1;
        k++;
      end
      r = (64'd3 << 30) - (m >> 1);
      for (int i = 0; i < NSTEPS; i++) begin
        e = ((64'd1 << 63) - m * r) >> 31;
        r = (r * e) >> 31;
      end
      sh = 62 - FRAC - k;
      for (int i = 0; i < 4; i++) begin
        p = (mag[i] * r + (64'd1 << (sh - 1))) >> sh;
        q[i] = q[i] < 0 ? -$signed(p) : $signed(p);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (q[i] > QBOUND) q[i] = QBOUND;
      else if (q[i] < -QBOUND) q[i] = -QBOUND;
    end
    t[0] = fshr(q[1] * v[2] - q[2] * v[1]) * 2;
    t[1] = fshr(q[2] * v[0] - q[0] * v[2]) * 2;
    t[2] = fshr(q[0] * v[1] - q[1] * v[0]) * 2;
    c[0] = fshr(q[1] * t[2] - q[2] * t[1]);
    c[1] = fshr(q[2] * t[0] - q[0] * t[2]);
    c[2] = fshr(q[0] * t[1] - q[1] * t[0]);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = v[i] + fshr(q[3] * t[i]) + c[i];
      if (s > 64'sh7fff_ffff) begin
        s = 64'sh7fff_ffff; sat = 1'b1;
      end else if (s < -64'sh8000_0000) begin
        s = -64'sh8000_0000; sat = 1'b1;
      end
      if (i == 0) res.rx = s[31:0];
      else if (i == 1) res.ry = s[31:0];
      else res.rz = s[31:0];
    end
    res.saturated = sat;
    rotate_item = res;
  endfunction

  // Driver: presents queued items, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rots.push_back(rotate_item({in_ch.quat_x, in_ch.quat_y, in_ch.quat_z,
                                              in_ch.quat_w, in_ch.vec_x, in_ch.vec_y,
                                              in_ch.vec_z}, epsilon_now));
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          tb_qvr_pkg::rot_req_t it;
          it = pending_items.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.quat_x <= it.qx; in_ch.quat_y <= it.qy;
          in_ch.quat_z <= it.qz; in_ch.quat_w <= it.qw;
          in_ch.vec_x  <= it.vx; in_ch.vec_y  <= it.vy; in_ch.vec_z <= it.vz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results, stalls the output at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item rot=%h %h %h",
                                         out_ch.rot_x, out_ch.rot_y, out_ch.rot_z);
        end else begin
          tb_qvr_pkg::rot_res_t ex;
          ex = expected_rots.pop_front();
          if (ex.rx !== out_ch.rot_x || ex.ry !== out_ch.rot_y || ex.rz !== out_ch.rot_z ||
              ex.zero_norm !== out_ch.zero_norm || ex.saturated !== out_ch.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp rot=%h %h %h zn=%b sat=%b got %h %h %h zn=%b sat=%b",
                       ex.rx, ex.ry, ex.rz, ex.zero_norm, ex.saturated,
                       out_ch.rot_x, out_ch.rot_y, out_ch.rot_z, out_ch.zero_norm,
                       out_ch.saturated);
          end
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] rnd_word(input int mode);
    case (mode)
      0: rnd_word = $urandom();
      1: rnd_word = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2: rnd_word = $urandom_range(1023) - 512;
      default: rnd_word = ($urandom_range(1)) ? 32'h7fff_ffff - $urandom_range(3)
                                             : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  function automatic tb_qvr_pkg::rot_req_t rnd_item();
    tb_qvr_pkg::rot_req_t it;
    int qm, vm;
    qm = $urandom_range(9);
    vm = $urandom_range(9);
    qm = qm < 3 ? 0 : qm < 7 ? 1 : qm < 9 ? 2 : 3;
    vm = vm < 3 ? 0 : vm < 8 ? 1 : vm < 9 ? 2 : 3;
    it.qx = rnd_word(qm); it.qy = rnd_word(qm); it.qz = rnd_word(qm); it.qw = rnd_word(qm);
    it.vx = rnd_word(vm); it.vy = rnd_word(vm); it.vz = rnd_word(vm);
    rnd_item = it;
  endfunction

  task automatic drain_and_write(input logic [15:0] eps);
    while (pending_items.size() > 0 || in_ch.valid || expected_rots.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= eps;
    epsilon_now <= eps;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tb_qvr_pkg::rot_req_t mk(input logic [31:0] a, b, c, d, e, f, g);
    tb_qvr_pkg::rot_req_t it;
    it = {a, b, c, d, e, f, g};
    mk = it;
  endfunction

  initial begin
    logic [15:0] eps_list[5];
    in_ch.valid = 1'b0;
    in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0; in_ch.quat_w = '0;
    in_ch.vec_x = '0; in_ch.vec_y = '0; in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
    epsilon_now = 16'd1;
    send_idle_pct = 21;
    recv_idle_pct = 46;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero quaternion, extremes, tiny norms, saturation
    pending_items.push_back(mk(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000));
    pending_items.push_back(mk(0, 0, 0, 0, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff));
    pending_items.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    pending_items.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_items.push_back(mk(1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    pending_items.push_back(mk(2, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    pending_items.push_back(mk(0, 0, 32'hffff_ffff, 0, 5, 6, 7));
    pending_items.push_back(mk(0, 0, 32'h0000_b505, 32'h0000_b505, 32'h0001_0000, 0, 0));
    pending_items.push_back(mk(32'h0001_0000, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    pending_items.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    pending_items.push_back(mk(32'h0000_8000, 32'hffff_8000, 32'h0000_8000, 32'hffff_8000,
                               32'h0003_0000, 32'hfffd_0000, 32'h0000_0001));

    eps_list = '{16'd0, 16'hffff, 16'd300, 16'd1, 16'd40000};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 46; recv_idle_pct = 21;
      end else if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < 250; i++) pending_items.push_back(rnd_item());
      drain_and_write(eps_list[ph]);
      pending_items.push_back(mk(0, 0, 0, 0, 1, 2, 3));
      pending_items.push_back(mk(0, 0, 0, eps_list[ph], 32'h0001_0000, 0, 32'h0001_0000));
      pending_items.push_back(mk(0, 0, 0, eps_list[ph] + 1, 32'h0001_0000, 0, 32'h0001_0000));
    end
    while (pending_items.size() > 0 || in_ch.valid || expected_rots.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_rots.size() == 0)
      $display("quaternion_vector_rotate_core verification clean");
    else
      $display("quaternion_vector_rotate_core verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("quaternion_vector_rotate_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qvr_pkg.sv
rtl/qvr_if.sv
rtl/qvr_norm.sv
rtl/qvr_recip.sv
rtl/qvr_rotate.sv
rtl/quaternion_vector_rotate_core.sv
verif/tb_qvr_if.sv
verif/tb_quaternion_vector_rotate_core.sv
